// File: src/dirty_tile_tracker_macros.svh
// ----------------------------------------------------------------------------
// dirty_tile_tracker_macros
// Assertion helpers for the dirty tile tracker. Each checks on the rising
// clock and stays quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef DIRTY_TILE_TRACKER_MACROS_SVH
`define DIRTY_TILE_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// dirty tile tracker.
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam int PAGES      = 8;
   localparam int COLUMNS    = 128;
   localparam int TILE_WIDTH = 8;
   localparam int TILES      = COLUMNS / TILE_WIDTH;
   localparam int MAX_OUT    = 16;

   localparam int OP_W    = 3;
   localparam int PAGE_W  = 3;
   localparam int COL_W   = 7;
   localparam int PIDX_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int TIDX_W  = (TILES > 1) ? $clog2(TILES) : 1;
   localparam int CNT_W   = $clog2(MAX_OUT + 1);
   localparam int TSHIFT  = $clog2(TILE_WIDTH);

   localparam logic [OP_W-1:0] OP_ADD_REGION = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_PAGE   = 3'd1;
   localparam logic [OP_W-1:0] OP_FORCE_FULL = 3'd2;
   localparam logic [OP_W-1:0] OP_SCAN_PAGE  = 3'd3;
   localparam logic [OP_W-1:0] OP_COMMIT     = 3'd4;

   typedef logic [TILES-1:0] tile_row_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic mark_region;
      logic mark_page;
      logic force_full;
      logic scan_load;
      logic commit;
      logic emit;
   } ctl_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic scan_empty;
      logic scan_last;
   } dp_status_type;

   function automatic logic page_in_range(input logic [PAGE_W-1:0] page);
      return 32'(page) < PAGES;
   endfunction

endpackage

// File: src/dtt_ctrl.sv
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer: decodes incoming transactions, walks a page scan and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module dtt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dtt_pkg::OP_W-1:0]    req_opcode,
   input  logic [dtt_pkg::PAGE_W-1:0]  req_page,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output dtt_pkg::ctl_cmd_type        cmd,
   input  dtt_pkg::dp_status_type      status
);
   import dtt_pkg::*;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      out_free;
   logic      page_ok;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign page_ok    = page_in_range(req_page);
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_opcode)
                  OP_ADD_REGION: cmd.mark_region = page_ok;
                  OP_ADD_PAGE:   cmd.mark_page   = page_ok;
                  OP_FORCE_FULL: cmd.force_full  = 1'b1;
                  OP_SCAN_PAGE: begin
                     if (page_ok) begin
                        cmd.scan_load = 1'b1;
                        state_in      = ST_SCAN;
                     end
                  end
                  OP_COMMIT:     cmd.commit      = 1'b1;
                  default:       ;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.scan_empty) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/dtt_datapath.sv
// ----------------------------------------------------------------------------
// dtt_datapath
// Tile bitmaps, scan mask with lowest-bit pick, and the response
// payload register.
// ----------------------------------------------------------------------------
module dtt_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dtt_pkg::PAGE_W-1:0]  req_page,
   input  logic [dtt_pkg::COL_W-1:0]   req_start_column,
   input  logic [dtt_pkg::COL_W-1:0]   req_end_column,
   input  logic                        req_transfer_failed,
   output logic [dtt_pkg::PAGE_W-1:0]  rsp_tile_page,
   output logic [dtt_pkg::COL_W-1:0]   rsp_tile_column,
   output logic                        rsp_last_tile,
   input  dtt_pkg::ctl_cmd_type        cmd,
   output dtt_pkg::dp_status_type      status
);
   import dtt_pkg::*;

   tile_row_type              prev_ff [PAGES];
   tile_row_type              cur_ff  [PAGES];
   tile_row_type              scan_mask_ff;
   logic [PAGE_W-1:0]         scan_page_ff;
   logic [CNT_W-1:0]          emit_cnt_ff;
   logic [PAGE_W-1:0]         tile_page_ff;
   logic [COL_W-1:0]          tile_column_ff;
   logic                      last_tile_ff;

   logic [PIDX_W-1:0]         pidx;
   logic [COL_W-1:0]          s_raw, e_raw, s_tile, e_tile;
   tile_row_type              region_mask;
   tile_row_type              merged_row;
   tile_row_type              remaining;
   logic [TIDX_W-1:0]         lo_idx;
   logic                      emit_last;

   assign pidx  = PIDX_W'(req_page);
   assign s_raw = req_start_column >> TSHIFT;
   assign e_raw = req_end_column >> TSHIFT;
   // Clamp columns past the last tile onto the last tile.
   assign s_tile = (32'(s_raw) > TILES - 1) ? COL_W'(TILES - 1) : s_raw;
   assign e_tile = (32'(e_raw) > TILES - 1) ? COL_W'(TILES - 1) : e_raw;

   always_comb begin
      for (int i = 0; i < TILES; i++) begin
         region_mask[i] = (COL_W'(i) >= s_tile) && (COL_W'(i) <= e_tile);
      end
   end

   assign merged_row = prev_ff[pidx] | cur_ff[pidx];

   // Pick the lowest marked tile still pending.
   always_comb begin
      lo_idx = '0;
      for (int i = TILES - 1; i >= 0; i--) begin
         if (scan_mask_ff[i]) begin
            lo_idx = TIDX_W'(i);
         end
      end
   end

   assign remaining  = scan_mask_ff & (scan_mask_ff - tile_row_type'(1));
   assign emit_last  = (remaining == '0) || (emit_cnt_ff == CNT_W'(MAX_OUT - 1));

   assign status.scan_empty = (scan_mask_ff == '0);
   assign status.scan_last  = emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PAGES; p++) begin
            prev_ff[p] <= '1;
            cur_ff[p]  <= '0;
         end
         scan_mask_ff <= '0;
         emit_cnt_ff  <= '0;
      end else begin
         if (cmd.mark_region) begin
            cur_ff[pidx] <= cur_ff[pidx] | region_mask;
         end
         if (cmd.mark_page) begin
            cur_ff[pidx] <= '1;
         end
         if (cmd.force_full) begin
            for (int p = 0; p < PAGES; p++) prev_ff[p] <= '1;
         end
         if (cmd.scan_load) begin
            prev_ff[pidx] <= merged_row;
            scan_mask_ff  <= merged_row;
            emit_cnt_ff   <= '0;
         end
         if (cmd.commit) begin
            for (int p = 0; p < PAGES; p++) begin
               prev_ff[p] <= req_transfer_failed ? '1 : cur_ff[p];
               cur_ff[p]  <= '0;
            end
         end
         if (cmd.emit) begin
            // Drop the rest of the page once the listing cap is reached.
            scan_mask_ff <= emit_last ? '0 : remaining;
            emit_cnt_ff  <= emit_cnt_ff + CNT_W'(1);
         end
      end
   end

   // Response payload and scan page: no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.scan_load) begin
         scan_page_ff <= req_page;
      end
      if (cmd.emit) begin
         tile_page_ff   <= scan_page_ff;
         tile_column_ff <= COL_W'(32'(lo_idx) * TILE_WIDTH);
         last_tile_ff   <= emit_last;
      end
   end

   assign rsp_tile_page   = tile_page_ff;
   assign rsp_tile_column = tile_column_ff;
   assign rsp_last_tile   = last_tile_ff;

endmodule

// File: src/dirty_tile_tracker.sv
// ----------------------------------------------------------------------------
// dirty_tile_tracker
// Dirty-tile bookkeeping for a paged display: two per-tile bitmaps with
// region marking, page scan listing and frame commit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command transaction: add region, add page, force full,
//   scan page or commit. rsp_* returns one transaction per dirty tile found
//   by a scan (up to 16), ascending by column, with rsp_last_tile on the last.
//   Both channels use valid/stall; a transaction moves when valid is high and
//   stall is low. rsp_valid comes straight from a register.
//   Add region, add page, force full and commit update the bitmaps at the
//   edge that accepts them and leave the controller idle, so the next
//   command is not stalled. A scan merges the page into the previous bitmap
//   in its accept cycle and loads the scan mask; the tile lister then emits
//   one tile per cycle (up to 16) from a lowest-set-bit pick on the scan
//   mask while the receiver does not stall, the last one returning to idle;
//   a clean page returns to idle with no tile. req_stall is high from the
//   cycle after the scan is accepted until it returns to idle.
//   Reset loads the previous bitmap with all ones and clears the current
//   bitmap, the scan mask and the response valid flag.
//   While the receiver stalls, the response register holds its tile and the
//   scan waits; other commands flow once the scan is done.
// ----------------------------------------------------------------------------
module dirty_tile_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dtt_pkg::OP_W-1:0]    req_opcode,
   input  logic [dtt_pkg::PAGE_W-1:0]  req_page,
   input  logic [dtt_pkg::COL_W-1:0]   req_start_column,
   input  logic [dtt_pkg::COL_W-1:0]   req_end_column,
   input  logic                        req_transfer_failed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dtt_pkg::PAGE_W-1:0]  rsp_tile_page,
   output logic [dtt_pkg::COL_W-1:0]   rsp_tile_column,
   output logic                        rsp_last_tile
);
   import dtt_pkg::*;

`include "dirty_tile_tracker_macros.svh"

   ctl_cmd_type   dp_cmd;
   dp_status_type dp_status;

   // Sequencer: decode commands, step the scan, own rsp_valid.
   dtt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_page   (req_page),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (dp_cmd),
      .status     (dp_status)
   );

   // Bitmaps, scan mask and response payload.
   dtt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_page            (req_page),
      .req_start_column    (req_start_column),
      .req_end_column      (req_end_column),
      .req_transfer_failed (req_transfer_failed),
      .rsp_tile_page       (rsp_tile_page),
      .rsp_tile_column     (rsp_tile_column),
      .rsp_last_tile       (rsp_last_tile),
      .cmd                 (dp_cmd),
      .status              (dp_status)
   );

   // Never overwrite a response that is still stalled.
   `DTT_ASSERT_SAME(a_emit_when_free, dp_cmd.emit, !rsp_valid || !rsp_stall, "emit over held tile")
   // Emit only while tiles remain in the scan mask.
   `DTT_ASSERT_SAME(a_emit_nonempty, dp_cmd.emit, !dp_status.scan_empty, "emit from empty scan")
   // The last tile of a scan returns the controller to idle.
   `DTT_ASSERT_NEXT(a_last_to_idle, dp_cmd.emit && dp_status.scan_last, !req_stall, "no idle")
   // A scan start blocks new commands in the next cycle.
   `DTT_ASSERT_NEXT(a_scan_busy, dp_cmd.scan_load, req_stall, "scan not busy")

endmodule
